@@ src/pnst_pkg.sv @@
// Shared types, constants and helper functions for the peak-normalized sample table.
package pnst_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int INDEX_W       = 12;
    localparam int LEN_W         = 13;
    localparam int TABLE_DEPTH_DEF = 4096;
    localparam logic [LEN_W-1:0] LEN_RESET = 13'd4096;

    // Quotient bits retired per divider cycle, and the quotient width.
    localparam int QUO_W         = 16;
    localparam int BITS_PER_STEP = 4;
    localparam int DIV_CYCLES    = QUO_W / BITS_PER_STEP;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_READ = 1'b1;

    localparam logic [SAMPLE_W:0] POS_MAX = 17'd32767;
    localparam logic [SAMPLE_W:0] NEG_MAG_MAX = 17'd32768;

    typedef struct packed {
        logic                        req_type;
        logic signed [SAMPLE_W-1:0]  sample;
        logic                        restart;
        logic [INDEX_W-1:0]          index;
    } req_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0]  value;
        logic                        in_range;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic read;
        logic prep;
        logic step;
        logic finish;
    } cmd_t;

    function automatic logic [SAMPLE_W-1:0] mag(input logic signed [SAMPLE_W-1:0] x);
        mag = x[SAMPLE_W-1] ? SAMPLE_W'(-x) : SAMPLE_W'(x);
    endfunction

endpackage

@@ src/peak_normalized_sample_table_top.sv @@
// Top level of the peak-normalized sample table: controller plus datapath.
//
//  channel   direction  handshake               payload
//  request   in         start, busy             req (pnst_pkg::req_t)
//  result    out        done (one-cycle strobe)  rsp (pnst_pkg::rsp_t)
//  config    in         cfg_we                  cfg_wdata (table length)
//
// A load word leaves the controller idle; busy stays low and the next word may follow at once.
// A read word passes through the registered memory read, the divider set-up, the 16-bit
// quotient at four bits per cycle, and the rounding.
// The result shows on rsp when done is high and holds until the next read finishes; it cannot be held off.
// Reset clears the count, the peak and sets the length to 4096; memory is not cleared.
module peak_normalized_sample_table_top #(
    parameter int TABLE_DEPTH = pnst_pkg::TABLE_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  pnst_pkg::req_t              req,
    input  logic                        cfg_we,
    input  logic [pnst_pkg::LEN_W-1:0]  cfg_wdata,
    output logic                        done,
    output pnst_pkg::rsp_t              rsp
);

    pnst_pkg::cmd_t cmd;

    pnst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req.req_type),
        .busy     (busy),
        .done     (done),
        .cmd      (cmd)
    );

    pnst_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .rsp       (rsp)
    );

endmodule

@@ src/pnst_ctrl.sv @@
// Controller state machine: sequences loads, the table read, the divider and the result.
module pnst_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              req_type,
    output logic              busy,
    output logic              done,
    output pnst_pkg::cmd_t    cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_FETCH  = 2'd1;
    localparam logic [1:0] S_DIVIDE = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;
    localparam int STEP_W = (pnst_pkg::DIV_CYCLES > 1) ? $clog2(pnst_pkg::DIV_CYCLES) : 1;
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(pnst_pkg::DIV_CYCLES - 1);

    logic [1:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              done_reg, done_next;
    logic              accept;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        done_next  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                step_next = '0;
                if (accept)
                begin
                    if (req_type == pnst_pkg::REQ_READ)
                    begin
                        cmd.read   = 1'b1;
                        state_next = S_FETCH;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                    end
                end
            end
            S_FETCH:
            begin
                cmd.prep   = 1'b1;
                state_next = S_DIVIDE;
            end
            S_DIVIDE:
            begin
                cmd.step  = 1'b1;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_LAST)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    a_done_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == S_FINISH))
        else $error("result strobe without a finished division");

    a_done_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result strobe while the controller is still busy");

    a_read_starts_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req_type == pnst_pkg::REQ_READ) |=> (state_reg == S_FETCH))
        else $error("accepted read did not start a table fetch");

endmodule

@@ src/pnst_dp.sv @@
// Datapath: sample memory, count and peak tracking, radix-16 divider and result rounding.
module pnst_dp #(
    parameter int TABLE_DEPTH = pnst_pkg::TABLE_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  pnst_pkg::cmd_t              cmd,
    input  pnst_pkg::req_t              req,
    input  logic                        cfg_we,
    input  logic [pnst_pkg::LEN_W-1:0]  cfg_wdata,
    output pnst_pkg::rsp_t              rsp
);

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int SW     = pnst_pkg::SAMPLE_W;
    localparam int LW     = pnst_pkg::LEN_W;
    localparam int QW     = pnst_pkg::QUO_W;

    logic signed [SW-1:0] mem [TABLE_DEPTH];

    logic [LW-1:0]        len_reg;
    logic [LW-1:0]        cnt_reg, cnt_next;
    logic signed [SW-1:0] peak_reg, peak_next;

    logic signed [SW-1:0] rd_data_reg;
    logic                 in_range_reg;
    logic [SW-1:0]        rem_reg;
    logic [QW-1:0]        dvd_reg;
    logic [SW-1:0]        den_reg;
    logic                 neg_reg;
    logic                 zero_peak_reg;
    pnst_pkg::rsp_t       rsp_reg;

    logic [LW-1:0]        cnt_base;
    logic signed [SW-1:0] peak_base;
    logic                 store_ok;
    logic [SW-1:0]        emag;
    logic [SW-1:0]        rem_step;
    logic [QW-1:0]        dvd_step;
    logic                 round_up;
    logic [SW:0]          quo_rnd;
    logic [SW:0]          mag_sat;
    logic signed [SW-1:0] value_calc;

    // Load: a restart clears the count and the peak before the sample is considered.
    always_comb
    begin
        cnt_base  = req.restart ? '0 : cnt_reg;
        peak_base = req.restart ? '0 : peak_reg;
        store_ok  = (cnt_base < len_reg) && (32'(cnt_base) < TABLE_DEPTH);
        cnt_next  = cnt_base;
        peak_next = peak_base;
        if (store_ok)
        begin
            cnt_next = cnt_base + 1'b1;
            if (pnst_pkg::mag(req.sample) > pnst_pkg::mag(peak_base))
            begin
                peak_next = req.sample;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && store_ok)
        begin
            mem[ADDR_W'(cnt_base)] <= req.sample;
        end
        if (cmd.read)
        begin
            rd_data_reg <= mem[ADDR_W'(req.index)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= pnst_pkg::LEN_RESET;
            cnt_reg  <= '0;
            peak_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                len_reg <= cfg_wdata;
            end
            if (cmd.load)
            begin
                cnt_reg  <= cnt_next;
                peak_reg <= peak_next;
            end
        end
    end

    // Four restoring steps per cycle; a remainder below the divisor stays below it.
    always_comb
    begin
        logic [SW:0] trial;
        rem_step = rem_reg;
        dvd_step = dvd_reg;
        for (int k = 0; k < pnst_pkg::BITS_PER_STEP; k++)
        begin
            trial    = {rem_step, dvd_step[QW-1]};
            dvd_step = {dvd_step[QW-2:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                rem_step    = SW'(trial - {1'b0, den_reg});
                dvd_step[0] = 1'b1;
            end
            else
            begin
                rem_step = SW'(trial);
            end
        end
    end

    assign emag = pnst_pkg::mag(rd_data_reg);

    // Rounding to nearest with ties away from zero, then saturation per sign.
    always_comb
    begin
        round_up = {rem_reg, 1'b0} >= {1'b0, den_reg};
        quo_rnd  = {1'b0, dvd_reg} + (SW+1)'(round_up);
        if (neg_reg)
        begin
            mag_sat    = (quo_rnd > pnst_pkg::NEG_MAG_MAX) ? pnst_pkg::NEG_MAG_MAX : quo_rnd;
            value_calc = SW'(-mag_sat);
        end
        else
        begin
            mag_sat    = (quo_rnd > pnst_pkg::POS_MAX) ? pnst_pkg::POS_MAX : quo_rnd;
            value_calc = SW'(mag_sat);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.read)
        begin
            in_range_reg <= {1'b0, req.index} < cnt_reg;
        end
        if (cmd.prep)
        begin
            // The dividend is |entry| * 2^15; its upper half seeds the remainder.
            rem_reg       <= {1'b0, emag[SW-1:1]};
            dvd_reg       <= {emag[0], {(QW-1){1'b0}}};
            den_reg       <= pnst_pkg::mag(peak_reg);
            neg_reg       <= rd_data_reg[SW-1] ^ peak_reg[SW-1];
            zero_peak_reg <= (peak_reg == '0);
        end
        else if (cmd.step)
        begin
            rem_reg <= rem_step;
            dvd_reg <= dvd_step;
        end
        if (cmd.finish)
        begin
            rsp_reg.in_range <= in_range_reg;
            if (!in_range_reg)
            begin
                rsp_reg.value <= '0;
            end
            else if (zero_peak_reg)
            begin
                rsp_reg.value <= rd_data_reg;
            end
            else
            begin
                rsp_reg.value <= value_calc;
            end
        end
    end

    assign rsp = rsp_reg;

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt_reg) <= TABLE_DEPTH)
        else $error("loaded count ran past the table depth");

    a_empty_zero_peak: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> (peak_reg == '0))
        else $error("empty table holds a nonzero peak");

endmodule
